[src/riffle_shuffle_engine_defines.svh]
// Assertion macros shared by the riffle shuffle engine RTL.
`ifndef RIFFLE_SHUFFLE_ENGINE_DEFINES_SVH
`define RIFFLE_SHUFFLE_ENGINE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RSE_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("riffle shuffle engine: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define RSE_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("riffle shuffle engine: next-cycle check failed");

`endif

[src/rse_pkg.sv]
`default_nettype none

package rse_pkg;

    // Deck and random fraction sizing
    localparam int DECK_SIZE   = 52;
    localparam int RANDOM_BITS = 16;

    // Fixed field widths
    localparam int KIND_W = 2;
    localparam int CARD_W = 6;
    localparam int CUT_W  = 6;
    localparam int POS_W  = 6;
    localparam int RAND_W = 16;
    localparam int SUIT_W = 2;
    localparam int RANK_W = 4;

    // Derived widths
    localparam int ADDR_W = $clog2(DECK_SIZE);
    localparam int CNT_W  = $clog2(DECK_SIZE + 1);

    localparam int SUIT_LEN = 13;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_CUT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRAW = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // capture the request and launch the deck read
        logic finish;   // read data is back: form the result, commit the draw
    } rse_cmd_t;

    // Suit of a card index: card / 13, low two bits
    function automatic logic [SUIT_W-1:0] card_suit(input logic [CARD_W-1:0] c);
        logic [SUIT_W-1:0] s;
        s = '0;
        priority if (c >= CARD_W'(4 * SUIT_LEN)) s = SUIT_W'(0);
        else if (c >= CARD_W'(3 * SUIT_LEN))     s = SUIT_W'(3);
        else if (c >= CARD_W'(2 * SUIT_LEN))     s = SUIT_W'(2);
        else if (c >= CARD_W'(SUIT_LEN))         s = SUIT_W'(1);
        else                                     s = SUIT_W'(0);
        return s;
    endfunction

    // Rank of a card index: card % 13 + 1
    function automatic logic [RANK_W-1:0] card_rank(input logic [CARD_W-1:0] c);
        logic [CARD_W-1:0] rem;
        rem = c;
        priority if (c >= CARD_W'(4 * SUIT_LEN)) rem = c - CARD_W'(4 * SUIT_LEN);
        else if (c >= CARD_W'(3 * SUIT_LEN))     rem = c - CARD_W'(3 * SUIT_LEN);
        else if (c >= CARD_W'(2 * SUIT_LEN))     rem = c - CARD_W'(2 * SUIT_LEN);
        else if (c >= CARD_W'(SUIT_LEN))         rem = c - CARD_W'(SUIT_LEN);
        else                                     rem = c;
        return RANK_W'(rem) + RANK_W'(1);
    endfunction

endpackage

`default_nettype wire

[src/rse_ram.sv]
`default_nettype none

module rse_ram #(
    parameter int DATA_W = 6,
    parameter int DEPTH  = 52
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [DATA_W-1:0]          wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [DATA_W-1:0]          rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/rse_ctrl.sv]
`default_nettype none
`include "riffle_shuffle_engine_defines.svh"

module rse_ctrl
    import rse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output rse_cmd_t  cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    // Take a request once the result register is free or being emptied
    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign cmd.accept = in_valid && in_ready;
    assign cmd.finish = (state_reg == ST_LOOKUP);
    assign out_valid  = out_valid_reg;

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.finish) out_valid_next = 1'b1;
        else if (out_ready)      out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `RSE_ASSERT_NEXT(a_accept_then_finish, clk, rst_n, cmd.accept, cmd.finish && !in_ready)
    `RSE_ASSERT_IMP(a_finish_has_room, clk, rst_n, cmd.finish, !out_valid_reg)

endmodule

`default_nettype wire

[src/rse_datapath.sv]
`default_nettype none
`include "riffle_shuffle_engine_defines.svh"

module rse_datapath
    import rse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rse_cmd_t          cmd,
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic [CUT_W-1:0]  cut_value,
    input  wire logic [RAND_W-1:0] random_fraction,
    input  wire logic [POS_W-1:0]  position,
    output logic      [CARD_W-1:0] card,
    output logic      [SUIT_W-1:0] suit,
    output logic      [RANK_W-1:0] rank,
    output logic                   took_top,
    output logic                   pass_done,
    output logic                   error
);

    localparam logic [CNT_W-1:0]   DECK_CNT = CNT_W'(DECK_SIZE);
    localparam logic [CUT_W-1:0]   CUT_MAX  = CUT_W'(DECK_SIZE - 1);
    localparam logic [POS_W:0]     POS_LIM  = (POS_W + 1)'(DECK_SIZE);
    localparam int                 PROD_W   = RANDOM_BITS + CNT_W;

    // Pass state
    logic             pass_active_reg, pass_active_next;
    logic [CNT_W-1:0] cut_reg, cut_next;
    logic [CNT_W-1:0] top_taken_reg, top_taken_next;
    logic [CNT_W-1:0] bottom_taken_reg, bottom_taken_next;
    logic             bank_reg, bank_next;
    logic             deck_loaded_reg, deck_loaded_next;

    // Request held between accept and finish
    logic              pend_err_reg;
    logic              pend_show_reg;
    logic              pend_draw_reg;
    logic              pend_top_reg;
    logic              pend_last_reg;
    logic [ADDR_W-1:0] pend_dst_reg;
    logic [ADDR_W-1:0] pend_addr_reg;

    // Result register
    logic [CARD_W-1:0] card_reg;
    logic [SUIT_W-1:0] suit_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              took_top_reg;
    logic              pass_done_reg;
    logic              error_reg;

    // Draw decision
    logic [CNT_W-1:0]       taken_sum;
    logic [CNT_W-1:0]       bottom_size;
    logic [CNT_W-1:0]       top_left;
    logic [CNT_W-1:0]       bot_left;
    logic [CNT_W-1:0]       remaining;
    logic [RANDOM_BITS-1:0] frac;
    logic [PROD_W-1:0]      product;
    logic [PROD_W-1:0]      threshold;
    logic                   take_top;
    logic [CNT_W-1:0]       src_idx;
    logic [CUT_W-1:0]       cut_clamped;
    logic                   pos_ok;

    // Request decode
    logic is_cut_ok, is_draw_ok, is_read_ok, is_err;
    logic [ADDR_W-1:0] rd_addr;

    // Deck banks
    logic              wr_en;
    logic [CARD_W-1:0] rdata0, rdata1;
    logic [CARD_W-1:0] card_sel;

    // Weigh top against bottom by cards left in each half
    assign taken_sum   = top_taken_reg + bottom_taken_reg;
    assign bottom_size = DECK_CNT - cut_reg;
    assign top_left    = (top_taken_reg < cut_reg) ? (cut_reg - top_taken_reg) : '0;
    assign bot_left    = (bottom_taken_reg < bottom_size) ?
                         (bottom_size - bottom_taken_reg) : '0;
    assign remaining   = top_left + bot_left;
    assign frac        = RANDOM_BITS'(random_fraction);
    assign product     = PROD_W'(frac) * PROD_W'(remaining);
    assign threshold   = {top_left, {RANDOM_BITS{1'b0}}};
    assign take_top    = product < threshold;
    assign src_idx     = take_top ? top_taken_reg : (cut_reg + bottom_taken_reg);

    // Clamp the cut point into the deck
    always_comb
    begin
        cut_clamped = cut_value;
        priority if (cut_value == '0)    cut_clamped = CUT_W'(1);
        else if (cut_value > CUT_MAX)    cut_clamped = CUT_MAX;
    end

    assign pos_ok = {1'b0, position} < POS_LIM;

    // Classify the request
    always_comb
    begin
        is_cut_ok  = 1'b0;
        is_draw_ok = 1'b0;
        is_read_ok = 1'b0;
        rd_addr    = '0;
        unique case (kind)
            KIND_CUT:  is_cut_ok  = !pass_active_reg;
            KIND_DRAW:
            begin
                is_draw_ok = pass_active_reg;
                rd_addr    = ADDR_W'(src_idx);
            end
            KIND_READ:
            begin
                is_read_ok = pos_ok;
                if (pos_ok)
                begin
                    rd_addr = ADDR_W'(position);
                end
            end
            default:   is_cut_ok = 1'b0;
        endcase
        is_err = !(is_cut_ok || is_draw_ok || is_read_ok);
    end

    // Update pass state on accept, commit the draw on finish
    always_comb
    begin
        pass_active_next  = pass_active_reg;
        cut_next          = cut_reg;
        top_taken_next    = top_taken_reg;
        bottom_taken_next = bottom_taken_reg;
        bank_next         = bank_reg;
        deck_loaded_next  = deck_loaded_reg;
        if (cmd.accept && is_cut_ok)
        begin
            cut_next          = CNT_W'(cut_clamped);
            top_taken_next    = '0;
            bottom_taken_next = '0;
            pass_active_next  = 1'b1;
        end
        if (cmd.accept && is_draw_ok)
        begin
            if (take_top)
            begin
                top_taken_next = top_taken_reg + CNT_W'(1);
            end
            else
            begin
                bottom_taken_next = bottom_taken_reg + CNT_W'(1);
            end
        end
        if (cmd.finish && pend_draw_reg && pend_last_reg)
        begin
            bank_next        = !bank_reg;
            deck_loaded_next = 1'b1;
            pass_active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_active_reg  <= 1'b0;
            cut_reg          <= '0;
            top_taken_reg    <= '0;
            bottom_taken_reg <= '0;
            bank_reg         <= 1'b0;
            deck_loaded_reg  <= 1'b0;
        end
        else
        begin
            pass_active_reg  <= pass_active_next;
            cut_reg          <= cut_next;
            top_taken_reg    <= top_taken_next;
            bottom_taken_reg <= bottom_taken_next;
            bank_reg         <= bank_next;
            deck_loaded_reg  <= deck_loaded_next;
        end
    end

    // Capture the request for the lookup cycle
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pend_err_reg  <= is_err;
            pend_show_reg <= is_draw_ok || is_read_ok;
            pend_draw_reg <= is_draw_ok;
            pend_top_reg  <= take_top;
            pend_last_reg <= (taken_sum + CNT_W'(1)) == DECK_CNT;
            pend_dst_reg  <= ADDR_W'(taken_sum);
            pend_addr_reg <= rd_addr;
        end
    end

    // Current deck is bank_reg, the deck being built is the other bank
    assign wr_en = cmd.finish && pend_draw_reg;

    rse_ram #(
        .DATA_W (CARD_W),
        .DEPTH  (DECK_SIZE)
    ) u_bank0 (
        .clk   (clk),
        .we    (wr_en && bank_reg),
        .waddr (pend_dst_reg),
        .wdata (card_sel),
        .raddr (rd_addr),
        .rdata (rdata0)
    );

    rse_ram #(
        .DATA_W (CARD_W),
        .DEPTH  (DECK_SIZE)
    ) u_bank1 (
        .clk   (clk),
        .we    (wr_en && !bank_reg),
        .waddr (pend_dst_reg),
        .wdata (card_sel),
        .raddr (rd_addr),
        .rdata (rdata1)
    );

    // Until the first pass ends the deck is the ordered one
    assign card_sel = !deck_loaded_reg ? CARD_W'(pend_addr_reg) :
                      (bank_reg ? rdata1 : rdata0);

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            card_reg      <= pend_show_reg ? card_sel : '0;
            suit_reg      <= pend_show_reg ? card_suit(card_sel) : '0;
            rank_reg      <= pend_show_reg ? card_rank(card_sel) : '0;
            took_top_reg  <= pend_draw_reg && pend_top_reg;
            pass_done_reg <= pend_draw_reg && pend_last_reg;
            error_reg     <= pend_err_reg;
        end
    end

    assign card      = card_reg;
    assign suit      = suit_reg;
    assign rank      = rank_reg;
    assign took_top  = took_top_reg;
    assign pass_done = pass_done_reg;
    assign error     = error_reg;

    `RSE_ASSERT_NEXT(a_last_draw_ends_pass, clk, rst_n,
        cmd.finish && pend_draw_reg && pend_last_reg, !pass_active_reg && deck_loaded_reg)
    `RSE_ASSERT_IMP(a_top_within_cut, clk, rst_n, pass_active_reg, top_taken_reg <= cut_reg)
    `RSE_ASSERT_NEXT(a_cut_starts_pass, clk, rst_n, cmd.accept && is_cut_ok,
        pass_active_reg && (taken_sum == '0))

endmodule

`default_nettype wire

[src/riffle_shuffle_engine.sv]
// Riffle shuffle engine: keeps a deck of 52 card indices, ordered 0..51 after
// reset, and runs riffle passes on it. A cut request starts a pass, each of
// the following 52 draw requests moves one card into the new deck (top or
// bottom half chosen from the random fraction), and the last draw swaps the
// new deck in. A read request returns the card at a position. Every request
// gives exactly one result; rejected requests set error with all else zero.
// Each request is accepted, then the registered read of the deck RAM comes
// back in the lookup state, and no new request is taken before then. The
// result sits in an output register and the next request is taken as soon as
// that register is empty or being read out. The deck lives in two RAM banks
// that trade roles at the end of a pass; there is no clearing pass after
// reset, the block is ready as soon as reset is released.
`default_nettype none

module riffle_shuffle_engine
    import rse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic [CUT_W-1:0]  cut_value,
    input  wire logic [RAND_W-1:0] random_fraction,
    input  wire logic [POS_W-1:0]  position,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [CARD_W-1:0] card,
    output logic      [SUIT_W-1:0] suit,
    output logic      [RANK_W-1:0] rank,
    output logic                   took_top,
    output logic                   pass_done,
    output logic                   error
);

    rse_cmd_t cmd;

    // Sequence requests and own the handshakes
    rse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Deck banks, pass counters and result register
    rse_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .kind            (kind),
        .cut_value       (cut_value),
        .random_fraction (random_fraction),
        .position        (position),
        .card            (card),
        .suit            (suit),
        .rank            (rank),
        .took_top        (took_top),
        .pass_done       (pass_done),
        .error           (error)
    );

endmodule

`default_nettype wire

[tb/riffle_deck_checker.sv]
`timescale 1ns / 1ps

module riffle_deck_checker
    import rse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [CUT_W-1:0]  cut_value,
    input  logic [RAND_W-1:0] random_fraction,
    input  logic [POS_W-1:0]  position,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [CARD_W-1:0] card,
    input  logic [SUIT_W-1:0] suit,
    input  logic [RANK_W-1:0] rank,
    input  logic              took_top,
    input  logic              pass_done,
    input  logic              error,
    output int                mismatches,
    output int                awaiting
);

    typedef struct packed {
        logic [CARD_W-1:0] card;
        logic [SUIT_W-1:0] suit;
        logic [RANK_W-1:0] rank;
        logic              took_top;
        logic              pass_done;
        logic              error;
    } deal_result_t;

    // Shadow deck, the deck being built by the current pass, and pass progress
    logic [CARD_W-1:0] deck    [DECK_SIZE];
    logic [CARD_W-1:0] riffled [DECK_SIZE];
    int                top_taken;
    int                bottom_taken;
    int                split_at;
    bit                pass_open;
    deal_result_t      owed_results [$];

    function automatic deal_result_t card_fields(input int c);
        deal_result_t res;
        res = '0;
        res.card = CARD_W'(c);
        res.suit = SUIT_W'(c / SUIT_LEN);
        res.rank = RANK_W'(c % SUIT_LEN + 1);
        return res;
    endfunction

    // Apply one request to the shadow deck and return the result it owes
    function automatic deal_result_t riffle_step(input logic [KIND_W-1:0] k,
                                                 input logic [CUT_W-1:0]  c,
                                                 input logic [RAND_W-1:0] r,
                                                 input logic [POS_W-1:0]  p);
        deal_result_t      res;
        int                top_left;
        int                bottom_left;
        int                src;
        int                picked;
        longint unsigned   scaled;
        longint unsigned   threshold;
        bit                from_top;
        res = '0;
        case (k)
            KIND_CUT:
            begin
                if (pass_open)
                    res.error = 1'b1;
                else
                begin
                    // Clamp the cut so both halves hold at least one card
                    if (c < 1)
                        split_at = 1;
                    else if (c > DECK_SIZE - 1)
                        split_at = DECK_SIZE - 1;
                    else
                        split_at = c;
                    top_taken    = 0;
                    bottom_taken = 0;
                    pass_open    = 1'b1;
                end
            end
            KIND_DRAW:
            begin
                if (!pass_open)
                    res.error = 1'b1;
                else
                begin
                    top_left    = (top_taken < split_at) ? split_at - top_taken : 0;
                    bottom_left = (bottom_taken < DECK_SIZE - split_at)
                                  ? DECK_SIZE - split_at - bottom_taken : 0;
                    // Exact integer compare of the fraction against the top share
                    scaled    = longint'(r) * longint'(top_left + bottom_left);
                    threshold = longint'(top_left) << RANDOM_BITS;
                    from_top  = scaled < threshold;
                    if (from_top)
                    begin
                        src = top_taken;
                        top_taken++;
                    end
                    else
                    begin
                        src = split_at + bottom_taken;
                        bottom_taken++;
                    end
                    picked = (src < DECK_SIZE) ? int'(deck[src]) : 0;
                    if (top_taken + bottom_taken - 1 < DECK_SIZE)
                        riffled[top_taken + bottom_taken - 1] = CARD_W'(picked);
                    res          = card_fields(picked);
                    res.took_top = from_top;
                    // Swap in the new deck once it is full
                    if (top_taken + bottom_taken >= DECK_SIZE)
                    begin
                        deck          = riffled;
                        pass_open     = 1'b0;
                        res.pass_done = 1'b1;
                    end
                end
            end
            KIND_READ:
            begin
                if (p >= DECK_SIZE)
                    res.error = 1'b1;
                else
                    res = card_fields(int'(deck[p]));
            end
            default:
                res.error = 1'b1;
        endcase
        return res;
    endfunction

    // Compare results in order, then queue the result of each new request
    always @(posedge clk or negedge rst_n)
    begin
        deal_result_t observed;
        deal_result_t owed;
        deal_result_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < DECK_SIZE; i++)
            begin
                deck[i]    = CARD_W'(i);
                riffled[i] = '0;
            end
            top_taken    = 0;
            bottom_taken = 0;
            split_at     = 0;
            pass_open    = 1'b0;
            owed_results.delete();
            mismatches   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                observed = {card, suit, rank, took_top, pass_done, error};
                if (owed_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display({"%0t: unexpected result card %0d suit %0d rank %0d ",
                                  "top %0b done %0b err %0b"},
                                 $realtime, card, suit, rank, took_top, pass_done, error);
                    mismatches++;
                end
                else
                begin
                    owed = owed_results[0];
                    owed_results.delete(0);
                    if (observed !== owed)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch expected card %0d suit %0d rank %0d top %0b ",
                                      "done %0b err %0b, got card %0d suit %0d rank %0d top %0b ",
                                      "done %0b err %0b"},
                                     $realtime, owed.card, owed.suit, owed.rank, owed.took_top,
                                     owed.pass_done, owed.error, card, suit, rank, took_top,
                                     pass_done, error);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                fresh        = riffle_step(kind, cut_value, random_fraction, position);
                owed_results = {owed_results, fresh};
            end
        end
        awaiting = owed_results.size();
    end

endmodule

[tb/riffle_shuffle_engine_test.sv]
`timescale 1ns / 1ps

module riffle_shuffle_engine_test;
    import rse_pkg::*;

    localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;
    localparam int RANDOM_REQUESTS = 500;
    localparam int HOLD_CYCLES     = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 20;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [KIND_W-1:0] kind;
    logic [CUT_W-1:0]  cut_value;
    logic [RAND_W-1:0] random_fraction;
    logic [POS_W-1:0]  position;
    logic              out_valid;
    logic              out_ready;
    logic [CARD_W-1:0] card;
    logic [SUIT_W-1:0] suit;
    logic [RANK_W-1:0] rank;
    logic              took_top;
    logic              pass_done;
    logic              error;

    int mismatches;
    int awaiting;
    bit hold_request;
    int burst_left;
    bit in_pass;
    int drawn;
    int idle_cycles;

    riffle_shuffle_engine dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .cut_value       (cut_value),
        .random_fraction (random_fraction),
        .position        (position),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .card            (card),
        .suit            (suit),
        .rank            (rank),
        .took_top        (took_top),
        .pass_done       (pass_done),
        .error           (error)
    );

    riffle_deck_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .cut_value       (cut_value),
        .random_fraction (random_fraction),
        .position        (position),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .card            (card),
        .suit            (suit),
        .rank            (rank),
        .took_top        (took_top),
        .pass_done       (pass_done),
        .error           (error),
        .mismatches      (mismatches),
        .awaiting        (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one request and hold it until taken; close the burst with a gap
    task automatic issue(input logic [KIND_W-1:0] k, input logic [CUT_W-1:0] c,
                         input logic [RAND_W-1:0] r, input logic [POS_W-1:0] p);
        in_valid        <= 1'b1;
        kind            <= k;
        cut_value       <= c;
        random_fraction <= r;
        position        <= p;
        do
            @(posedge clk);
        while (!in_ready);
        // Track pass progress to keep most sequences well formed
        if (k == KIND_CUT && !in_pass)
        begin
            in_pass = 1'b1;
            drawn   = 0;
        end
        else if (k == KIND_DRAW && in_pass)
        begin
            drawn++;
            if (drawn == DECK_SIZE)
                in_pass = 1'b0;
        end
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                : $urandom_range(1, 4))
                @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    // Drop valid and hold until every owed result is back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (awaiting != 0);
    endtask

    function automatic logic [RAND_W-1:0] pick_fraction();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return RAND_W'($urandom_range(0, 255));
            3:       return RAND_W'($urandom_range(65280, 65535));
            default: return RAND_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CUT_W-1:0] pick_cut();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CUT_W'($urandom_range(DECK_SIZE, 63));
            2:       return CUT_W'(1);
            3:       return CUT_W'(DECK_SIZE - 1);
            default: return CUT_W'($urandom_range(1, DECK_SIZE - 1));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 7) == 0)
            return POS_W'($urandom_range(DECK_SIZE, 63));
        return POS_W'($urandom_range(0, DECK_SIZE - 1));
    endfunction

    // Receiver: stall pattern of its own, plus a long hold-off on request
    initial
    begin
        int         mode;
        int         stretch;
        logic [7:0] pattern;
        out_ready = 1'b0;
        mode      = 0;
        stretch   = 0;
        pattern   = 8'hA5;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(8, 80);
                    pattern = 8'($urandom);
                end
                stretch--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        out_ready <= pattern[0];
                        pattern = {pattern[0], pattern[7:1]};
                    end
                endcase
            end
        end
    end

    // Watchdog: end the run when no request or result moves for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int roll;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        kind            = KIND_CUT;
        cut_value       = '0;
        random_fraction = '0;
        position        = '0;
        hold_request    = 1'b0;
        burst_left      = $urandom_range(1, 30);
        in_pass         = 1'b0;
        drawn           = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reads at the deck edges and past its end
        issue(KIND_READ, 6'($urandom), 16'($urandom), 6'd0);
        issue(KIND_READ, 6'($urandom), 16'($urandom), 6'(DECK_SIZE - 1));
        issue(KIND_READ, 6'($urandom), 16'($urandom), 6'(DECK_SIZE));
        issue(KIND_READ, 6'($urandom), 16'($urandom), '1);
        // Draw with no pass open, unused kind
        issue(KIND_DRAW, '0, '1, '0);
        issue(KIND_BAD, '1, '1, '1);
        // Cut clamped down, then a cut while the pass is open
        issue(KIND_CUT, '1, '0, '0);
        issue(KIND_CUT, '0, 16'($urandom), 6'($urandom));
        // Bottom half holds one card: empty it, then draws fall to the top
        issue(KIND_DRAW, 6'($urandom), '1, 6'($urandom));
        issue(KIND_DRAW, 6'($urandom), '1, 6'($urandom));
        issue(KIND_DRAW, 6'($urandom), '0, 6'($urandom));
        issue(KIND_DRAW, 6'($urandom), '0, 6'($urandom));
        // Reads and noise in the middle of a pass
        issue(KIND_READ, 6'($urandom), 16'($urandom), 6'd0);
        issue(KIND_READ, 6'($urandom), 16'($urandom), '1);
        issue(KIND_BAD, '0, '0, '0);
        issue(KIND_DRAW, 6'($urandom), 16'h8000, 6'($urandom));

        // Random: mostly whole passes, with stray requests mixed in
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == 150 || n == 350)
                wait_for_results();
            if (n == 250)
            begin
                hold_request = 1'b1;
                burst_left   = 60;
            end
            roll = $urandom_range(0, 99);
            if (in_pass)
            begin
                if (roll < 88)
                    issue(KIND_DRAW, 6'($urandom), pick_fraction(), 6'($urandom));
                else if (roll < 93)
                    issue(KIND_READ, 6'($urandom), 16'($urandom), pick_position());
                else if (roll < 97)
                    issue(KIND_CUT, pick_cut(), 16'($urandom), 6'($urandom));
                else
                    issue(KIND_BAD, 6'($urandom), 16'($urandom), 6'($urandom));
            end
            else
            begin
                if (roll < 75)
                    issue(KIND_CUT, pick_cut(), 16'($urandom), 6'($urandom));
                else if (roll < 90)
                    issue(KIND_READ, 6'($urandom), 16'($urandom), pick_position());
                else if (roll < 96)
                    issue(KIND_DRAW, 6'($urandom), pick_fraction(), 6'($urandom));
                else
                    issue(KIND_BAD, 6'($urandom), 16'($urandom), 6'($urandom));
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
